FILE: src/idc_pkg.sv
package idc_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int SUM_W      = 34;
	localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
	localparam int SQRT_TOP   = 2 * ((DATA_WIDTH - 2) / 2);

	localparam logic [DATA_WIDTH-1:0] SQRT_BIT = DATA_WIDTH'(1) << SQRT_TOP;

	localparam logic [1:0] CLS_DEFICIENT = 2'd0;
	localparam logic [1:0] CLS_PERFECT   = 2'd1;
	localparam logic [1:0] CLS_ABUNDANT  = 2'd2;

	typedef struct packed {
		logic                  start;
		logic [DATA_WIDTH-1:0] dividend;
		logic [DATA_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DATA_WIDTH-1:0] quotient;
		logic [DATA_WIDTH-1:0] remainder;
	} div_rsp_t;

endpackage

FILE: src/idc_div.sv
module idc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  idc_pkg::div_req_t req,
	output idc_pkg::div_rsp_t rsp
);

	logic                              run_q;
	logic                              done_q;
	logic [idc_pkg::CNT_W-1:0]         cnt_q;
	logic [idc_pkg::DATA_WIDTH-1:0]    rem_q;
	logic [idc_pkg::DATA_WIDTH-1:0]    quo_q;
	logic [idc_pkg::DATA_WIDTH-1:0]    dsr_q;
	logic [idc_pkg::DATA_WIDTH:0]      trial;
	logic [idc_pkg::DATA_WIDTH:0]      diff;

	assign trial = {rem_q, quo_q[idc_pkg::DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= idc_pkg::CNT_W'(idc_pkg::DATA_WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - idc_pkg::CNT_W'(1);
				if (cnt_q == idc_pkg::CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (run_q) begin
			if (diff[idc_pkg::DATA_WIDTH]) begin
				rem_q <= trial[idc_pkg::DATA_WIDTH-1:0];
			end else begin
				rem_q <= diff[idc_pkg::DATA_WIDTH-1:0];
			end
			quo_q <= {quo_q[idc_pkg::DATA_WIDTH-2:0], ~diff[idc_pkg::DATA_WIDTH]};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

FILE: src/integer_divisor_classifier_top.sv
// Classifies one signed number per transaction: prime by trial division, perfect square,
// proper-divisor sum and deficient/perfect/abundant class. A transaction is taken when
// start is high and busy is low; busy stays high until the result appears on the output
// ports for exactly one cycle with done high. The receiver cannot stall, so the result
// must be captured in that cycle. An item first takes the integer square root, then runs one
// division for each trial divisor from 2 to the root on the one shared restoring divider
// that works one quotient bit per cycle, then ends the search and presents the result;
// numbers of one or less skip the search.
module integer_divisor_classifier_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] number,
	output logic        done,
	output logic        is_prime,
	output logic        is_square,
	output logic [33:0] divisor_sum,
	output logic [1:0]  sum_class
);

	localparam int W = idc_pkg::DATA_WIDTH;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQRT = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t                   state_q;
	logic                     neg_q;
	logic                     gt1_q;
	logic                     found_q;
	logic [W-1:0]             u_q;
	logic [W-1:0]             rem_q;
	logic [W-1:0]             res_q;
	logic [W-1:0]             bit_q;
	logic [W-1:0]             d_q;
	logic [idc_pkg::SUM_W-1:0] sum_q;
	logic [W:0]               cand;
	logic                     take;
	logic [W-1:0]             q_add;
	idc_pkg::div_req_t        div_req;
	idc_pkg::div_rsp_t        div_rsp;

	assign cand  = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = {1'b0, rem_q} >= cand;
	assign q_add = (div_rsp.quotient == d_q) ? '0 : div_rsp.quotient;

	assign div_req.start    = (state_q == ST_LOAD) && (d_q <= res_q);
	assign div_req.dividend = u_q;
	assign div_req.divisor  = d_q;

	idc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (bit_q[0]) begin
						state_q <= gt1_q ? ST_LOAD : ST_DONE;
					end
				end
				ST_LOAD: begin
					state_q <= (d_q <= res_q) ? ST_WAIT : ST_DONE;
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				u_q     <= number[W-1:0];
				rem_q   <= number[W-1:0];
				neg_q   <= number[W-1];
				gt1_q   <= !number[W-1] && (number[W-1:0] > W'(1));
				res_q   <= '0;
				bit_q   <= idc_pkg::SQRT_BIT;
				d_q     <= W'(2);
				found_q <= 1'b0;
				sum_q   <= '0;
			end
			ST_SQRT: begin
				if (take) begin
					rem_q <= rem_q - cand[W-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (gt1_q) begin
					sum_q <= idc_pkg::SUM_W'(1);
				end
			end
			ST_WAIT: begin
				if (div_rsp.done) begin
					if (div_rsp.remainder == '0) begin
						found_q <= 1'b1;
						sum_q   <= sum_q + idc_pkg::SUM_W'(d_q) + idc_pkg::SUM_W'(q_add);
					end
					d_q <= d_q + W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_DONE);
	assign is_prime    = gt1_q && !found_q;
	assign is_square   = !neg_q && (rem_q == '0);
	assign divisor_sum = sum_q;

	always_comb begin
		if (neg_q) begin
			sum_class = idc_pkg::CLS_ABUNDANT;
		end else if (sum_q < idc_pkg::SUM_W'(u_q)) begin
			sum_class = idc_pkg::CLS_DEFICIENT;
		end else if (sum_q == idc_pkg::SUM_W'(u_q)) begin
			sum_class = idc_pkg::CLS_PERFECT;
		end else begin
			sum_class = idc_pkg::CLS_ABUNDANT;
		end
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction not busy");

	a_prime_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_prime) |-> (divisor_sum == 34'd1 && sum_class == idc_pkg::CLS_DEFICIENT))
		else $error("prime with wrong divisor sum");

endmodule

FILE: bench/tb.sv
module tb;

	typedef struct {
		logic [31:0]               value;
		logic                      prime;
		logic                      square;
		logic [idc_pkg::SUM_W-1:0] dsum;
		logic [1:0]                cls;
	} divisor_report_t;

	localparam int IDLE_LIMIT   = 8_000_000;
	localparam int TAIL_ITEMS   = 15;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 78;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] number = '0;
	logic        done;
	logic        is_prime;
	logic        is_square;
	logic [33:0] divisor_sum;
	logic [1:0]  sum_class;

	logic [31:0]     pending_numbers [$];
	divisor_report_t expected_reports [$];
	divisor_report_t want;
	logic [31:0]     directed_numbers [0:21];
	logic [31:0]     draw;
	int              gap_cycles = 0;
	int              accepted_count = 0;
	int              total_items = 0;
	int              error_count = 0;
	int              idle_cycles = 0;
	int unsigned     pick;

	integer_divisor_classifier_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.number      (number),
		.done        (done),
		.is_prime    (is_prime),
		.is_square   (is_square),
		.divisor_sum (divisor_sum),
		.sum_class   (sum_class)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic divisor_report_t classify_number(input logic [31:0] raw);
		divisor_report_t rep;
		logic [idc_pkg::DATA_WIDTH-1:0] low;
		longint value;
		longint unsigned mag;
		longint unsigned root;
		longint unsigned dsum;
		longint unsigned d;
		logic found;
		low = raw[idc_pkg::DATA_WIDTH-1:0];
		value = $signed(low);
		mag = 0;
		dsum = 0;
		rep.value = raw;
		rep.prime = 1'b0;
		rep.square = 1'b0;
		if (value >= 0) begin
			mag = value;
			root = int_sqrt(mag);
			rep.square = (root * root == mag);
			if (value > 1) begin
				found = 1'b0;
				dsum = 1;
				for (d = 2; d <= root; d++) begin
					if (mag % d == 0) begin
						found = 1'b1;
						dsum = dsum + d;
						if (mag / d != d)
							dsum = dsum + mag / d;
					end
				end
				rep.prime = !found;
			end
		end
		if (value < 0)
			rep.cls = idc_pkg::CLS_ABUNDANT;
		else if (dsum < mag)
			rep.cls = idc_pkg::CLS_DEFICIENT;
		else if (dsum == mag)
			rep.cls = idc_pkg::CLS_PERFECT;
		else
			rep.cls = idc_pkg::CLS_ABUNDANT;
		rep.dsum = dsum[idc_pkg::SUM_W-1:0];
		return rep;
	endfunction

	task automatic flag_mismatch(input string msg);
		error_count++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			number <= '0;
			gap_cycles <= 0;
		end else if (start && !busy) begin
			expected_reports.push_back(classify_number(number));
			accepted_count <= accepted_count + 1;
			if (pending_numbers.size() > TAIL_ITEMS && $urandom_range(0, 2) == 0) begin
				start <= 1'b0;
				gap_cycles <= $urandom_range(1, 4);
			end else if (pending_numbers.size() != 0) begin
				number <= pending_numbers.pop_front();
			end else begin
				start <= 1'b0;
			end
		end else if (!start) begin
			if (gap_cycles != 0) begin
				if (!busy)
					gap_cycles <= gap_cycles - 1;
			end else if (pending_numbers.size() != 0) begin
				start <= 1'b1;
				number <= pending_numbers.pop_front();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_reports.size() == 0) begin
				flag_mismatch("result with no transaction pending");
			end else begin
				want = expected_reports.pop_front();
				if (is_prime !== want.prime)
					flag_mismatch($sformatf("number %0d is_prime %b want %b",
						$signed(want.value), is_prime, want.prime));
				if (is_square !== want.square)
					flag_mismatch($sformatf("number %0d is_square %b want %b",
						$signed(want.value), is_square, want.square));
				if (divisor_sum !== want.dsum)
					flag_mismatch($sformatf("number %0d divisor_sum %0d want %0d",
						$signed(want.value), divisor_sum, want.dsum));
				if (sum_class !== want.cls)
					flag_mismatch($sformatf("number %0d sum_class %0d want %0d",
						$signed(want.value), sum_class, want.cls));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		directed_numbers = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd12,
			32'd28, 32'd49, 32'd97, 32'd121, 32'd496, 32'd945, 32'd1024, 32'd8128,
			32'd65536, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hAAAA_AAAA
		};
		foreach (directed_numbers[i])
			pending_numbers.push_back(directed_numbers[i]);
		repeat (RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				draw = $urandom | 32'h8000_0000;
			else if (pick < 65)
				draw = $urandom_range(0, 4095);
			else if (pick < 80)
				draw = $urandom_range(0, 65535);
			else if (pick < 90) begin
				draw = $urandom_range(0, 255);
				draw = draw * draw;
			end else if (pick < 95)
				draw = $urandom_range(2, 255) * $urandom_range(2, 255);
			else
				draw = $urandom_range(0, 1 << 20);
			pending_numbers.push_back(draw);
		end
		total_items = pending_numbers.size();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (accepted_count != total_items || expected_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

FILE: files.f
src/idc_pkg.sv
src/idc_div.sv
src/integer_divisor_classifier_top.sv
bench/tb.sv
